/* rtl/core/spad_pkg.sv */
// Package for the shortest-path-around-disk block.
// Holds widths, angle constants, the CORDIC lane type and its step functions.
// Used by the top level and by the testbench; depends on nothing.
package spad_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int SQ_STEPS = 34;
  localparam int REM_W = 70;
  localparam int ROOT_W = 34;
  localparam int ANG_W = 35;
  localparam int WRAP_W = 37;
  localparam int LEN_W = 40;

  localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;
  localparam logic signed [WRAP_W-1:0] ANG_2PI = 37'sd6746518852;
  localparam logic [LEN_W:0] LEN_MAX = 41'h0FFFFFFFFFF;

  // One CORDIC vector in flight: scaled coordinates and accumulated angle.
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [ANG_W-1:0] z;
  } cv_t;

  // One square root lane: remainder, partial root and the point offset.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } sq_lane_t;

  // Elementary angle atan(2^-i) in Q30 radians.
  function automatic logic signed [ANG_W-1:0] atan_step(input int i);
    logic signed [ANG_W-1:0] a;
    a = '0;
    case (i)
      0: a = 35'sd843314856;
      1: a = 35'sd497837829;
      2: a = 35'sd263043836;
      3: a = 35'sd133525158;
      4: a = 35'sd67021686;
      5: a = 35'sd33543515;
      6: a = 35'sd16775850;
      7: a = 35'sd8388437;
      8: a = 35'sd4194282;
      9: a = 35'sd2097149;
      10: a = 35'sd1048575;
      default: begin
        if (i <= 30) begin
          a = 35'sd1 <<< (30 - i);
        end
      end
    endcase
    return a;
  endfunction

  // Scale a vector by 2^28 and turn it by pi when it points to the left.
  function automatic cv_t vec_init(input logic signed [34:0] x, input logic signed [34:0] y);
    cv_t v;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    xs = {{29{x[34]}}, x} <<< 28;
    ys = {{29{y[34]}}, y} <<< 28;
    if (x < 0) begin
      v.z = (y >= 0) ? ANG_PI : -ANG_PI;
      v.x = -xs;
      v.y = -ys;
    end else begin
      v.z = '0;
      v.x = xs;
      v.y = ys;
    end
    return v;
  endfunction

  // One vectoring micro-rotation; shifts round toward minus infinity.
  function automatic cv_t vec_step(input cv_t v, input int i);
    cv_t n;
    if (v.y > 0) begin
      n.x = v.x + (v.y >>> i);
      n.y = v.y - (v.x >>> i);
      n.z = v.z + atan_step(i);
    end else begin
      n.x = v.x - (v.y >>> i);
      n.y = v.y + (v.x >>> i);
      n.z = v.z - atan_step(i);
    end
    return n;
  endfunction

  // Bring an angle into one turn with a single add or subtract of 2pi.
  function automatic logic signed [WRAP_W-1:0] wrap_turn(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] w;
    w = (a < 0) ? a + ANG_2PI : a;
    if (w >= ANG_2PI) begin
      w = w - ANG_2PI;
    end
    return w;
  endfunction

endpackage

/* rtl/core/spad_query_if.sv */
// Input channel of the shortest-path-around-disk block.
// Carries valid, ready and one query beat; no dependencies.
interface spad_query_if;
  logic valid;
  logic ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic [30:0] radius;

  modport source (output valid, first_x, first_y, second_x, second_y, center_x, center_y,
                  radius, input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, center_x, center_y,
                radius, output ready);
endinterface

/* rtl/core/spad_result_if.sv */
// Output channel of the shortest-path-around-disk block.
// Carries valid, ready and one result beat; no dependencies.
interface spad_result_if;
  logic valid;
  logic ready;
  logic [39:0] path_length;
  logic inside_error;

  modport source (output valid, path_length, inside_error, input ready);
  modport sink (input valid, path_length, inside_error, output ready);
endinterface

/* rtl/core/shortest_path_around_disk.sv */
// Top level of the shortest-path-around-disk block.
// Depends on spad_pkg, spad_query_if and spad_result_if.
//
//   channel   dir  beat contents
//   query     in   two points, disk center and radius (Q16.16)
//   result    out  path length (Q24.16, saturating) and inside error flag
//
// One beat enters per cycle while the output is not stalled; the path runs through 3 setup stages,
// 34 square root digit stages, CORDIC_STEPS + 1 CORDIC stages and 5 finishing stages.
// Reset clears only the valid bits of the pipeline.
// When a finished beat waits at the output, the whole pipeline holds and query
// ready drops in the same cycle; nothing is dropped or repeated.
module shortest_path_around_disk
  import spad_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic clk,
  input logic rst,
  spad_query_if.sink query,
  spad_result_if.source result
);

  logic adv;

  // Front stages.
  logic v1, v2, v3;
  logic [30:0] r1, r2;
  logic signed [32:0] dx1 [2];
  logic signed [32:0] dy1 [2];
  logic signed [32:0] dx2 [2];
  logic signed [32:0] dy2 [2];
  logic [65:0] sx [2];
  logic [65:0] sy [2];
  logic [61:0] rr;

  // Square root pipeline.
  logic sq_valid [SQ_STEPS+1];
  logic sq_err [SQ_STEPS+1];
  logic [30:0] sq_r [SQ_STEPS+1];
  sq_lane_t sq_lane [SQ_STEPS+1][2];

  // CORDIC pipeline: lanes are phi1, beta1, phi2, beta2.
  logic cr_valid [CORDIC_STEPS+1];
  logic cr_err [CORDIC_STEPS+1];
  logic [30:0] cr_r [CORDIC_STEPS+1];
  logic [ROOT_W-1:0] cr_t [CORDIC_STEPS+1][2];
  cv_t cv [CORDIC_STEPS+1][4];

  // Finishing stages.
  logic pv [4];
  logic pe [4];
  logic [30:0] pr [4];
  logic [ROOT_W-1:0] pt [4][2];
  logic signed [WRAP_W-1:0] ang [4];
  logic signed [WRAP_W:0] gap [4];
  logic [32:0] best;
  logic [63:0] prod;

  logic o_valid;
  logic o_err;
  logic [LEN_W-1:0] o_len;

  // The pipeline moves as a whole unless the output beat is stuck.
  assign adv = !o_valid || result.ready;
  assign query.ready = adv;

  // Valid bits of the front.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= query.valid;
      v2 <= v1;
    end
  end

  // Stage 1: offsets from the center.
  always_ff @(posedge clk) begin
    if (adv) begin
      r1 <= query.radius;
      dx1[0] <= 33'(query.first_x) - 33'(query.center_x);
      dy1[0] <= 33'(query.first_y) - 33'(query.center_y);
      dx1[1] <= 33'(query.second_x) - 33'(query.center_x);
      dy1[1] <= 33'(query.second_y) - 33'(query.center_y);
    end
  end

  // Stage 2: exact squares.
  always_ff @(posedge clk) begin
    logic [32:0] ax;
    logic [32:0] ay;
    if (adv) begin
      r2 <= r1;
      rr <= {31'b0, r1} * {31'b0, r1};
      for (int p = 0; p < 2; p++) begin
        ax = dx1[p][32] ? 33'(-dx1[p]) : 33'(dx1[p]);
        ay = dy1[p][32] ? 33'(-dy1[p]) : 33'(dy1[p]);
        sx[p] <= {33'b0, ax} * {33'b0, ax};
        sy[p] <= {33'b0, ay} * {33'b0, ay};
        dx2[p] <= dx1[p];
        dy2[p] <= dy1[p];
      end
    end
  end

  // Stage 3: d^2 against r^2, and the radicand of the tangent length.
  assign v3 = v2;
  always_ff @(posedge clk) begin
    logic [66:0] d2;
    logic in_any;
    if (adv) begin
      in_any = 1'b0;
      for (int p = 0; p < 2; p++) begin
        d2 = 67'(sx[p]) + 67'(sy[p]);
        if (d2 <= 67'(rr)) begin
          in_any = 1'b1;
        end
        sq_lane[0][p].rem <= REM_W'(d2) - REM_W'(rr);
        sq_lane[0][p].root <= '0;
        sq_lane[0][p].dx <= dx2[p];
        sq_lane[0][p].dy <= dy2[p];
      end
      sq_err[0] <= in_any;
      sq_r[0] <= r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (adv) begin
      sq_valid[0] <= v3;
    end
  end

  // Square root: one result bit per stage, most significant first.
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - k;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (adv) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      logic [REM_W-1:0] trial;
      if (adv) begin
        sq_err[k+1] <= sq_err[k];
        sq_r[k+1] <= sq_r[k];
        for (int p = 0; p < 2; p++) begin
          trial = (REM_W'(sq_lane[k][p].root) << (B + 1)) + (REM_W'(1) << (2 * B));
          sq_lane[k+1][p].dx <= sq_lane[k][p].dx;
          sq_lane[k+1][p].dy <= sq_lane[k][p].dy;
          if (sq_lane[k][p].rem >= trial) begin
            sq_lane[k+1][p].rem <= sq_lane[k][p].rem - trial;
            sq_lane[k+1][p].root <= sq_lane[k][p].root | (ROOT_W'(1) << B);
          end else begin
            sq_lane[k+1][p].rem <= sq_lane[k][p].rem;
            sq_lane[k+1][p].root <= sq_lane[k][p].root;
          end
        end
      end
    end
  end

  // CORDIC entry: point angle and half angle vectors for both points.
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_valid[0] <= 1'b0;
    end else if (adv) begin
      cr_valid[0] <= sq_valid[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cr_err[0] <= sq_err[SQ_STEPS];
      cr_r[0] <= sq_r[SQ_STEPS];
      for (int p = 0; p < 2; p++) begin
        cr_t[0][p] <= sq_lane[SQ_STEPS][p].root;
        cv[0][2*p] <= vec_init(35'(sq_lane[SQ_STEPS][p].dx), 35'(sq_lane[SQ_STEPS][p].dy));
        cv[0][2*p+1] <= vec_init({4'b0, sq_r[SQ_STEPS]},
                                 {1'b0, sq_lane[SQ_STEPS][p].root});
      end
    end
  end

  // CORDIC iterations, one micro-rotation per stage on all four lanes.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cr_valid[i+1] <= 1'b0;
      end else if (adv) begin
        cr_valid[i+1] <= cr_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cr_err[i+1] <= cr_err[i];
        cr_r[i+1] <= cr_r[i];
        cr_t[i+1] <= cr_t[i];
        for (int l = 0; l < 4; l++) begin
          cv[i+1][l] <= vec_step(cv[i][l], i);
        end
      end
    end
  end

  // Valid bits of the finishing stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '{default: 1'b0};
      o_valid <= 1'b0;
    end else if (adv) begin
      pv[0] <= cr_valid[CORDIC_STEPS];
      for (int s = 1; s < 4; s++) begin
        pv[s] <= pv[s-1];
      end
      o_valid <= pv[3];
    end
  end

  // Side data rides along the finishing stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      pe[0] <= cr_err[CORDIC_STEPS];
      pr[0] <= cr_r[CORDIC_STEPS];
      pt[0] <= cr_t[CORDIC_STEPS];
      for (int s = 1; s < 4; s++) begin
        pe[s] <= pe[s-1];
        pr[s] <= pr[s-1];
        pt[s] <= pt[s-1];
      end
    end
  end

  // Finish 1: the four tangent point angles, each within one turn.
  always_ff @(posedge clk) begin
    logic signed [WRAP_W-1:0] phi;
    logic signed [WRAP_W-1:0] beta;
    if (adv) begin
      for (int p = 0; p < 2; p++) begin
        phi = WRAP_W'(cv[CORDIC_STEPS][2*p].z);
        beta = WRAP_W'(cv[CORDIC_STEPS][2*p+1].z);
        ang[2*p] <= wrap_turn(phi + beta);
        ang[2*p+1] <= wrap_turn(phi - beta);
      end
    end
  end

  // Finish 2: shorter way round for each pair of tangent points.
  always_ff @(posedge clk) begin
    logic signed [WRAP_W:0] g;
    logic signed [WRAP_W:0] alt;
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          g = (WRAP_W+1)'(ang[i]) - (WRAP_W+1)'(ang[2+j]);
          if (g < 0) begin
            g = -g;
          end
          alt = (WRAP_W+1)'(ANG_2PI) - g;
          gap[2*i+j] <= (alt < g) ? alt : g;
        end
      end
    end
  end

  // Finish 3: smallest gap.
  always_ff @(posedge clk) begin
    logic signed [WRAP_W:0] m;
    if (adv) begin
      m = (WRAP_W+1)'(ANG_2PI);
      for (int q = 0; q < 4; q++) begin
        if (gap[q] < m) begin
          m = gap[q];
        end
      end
      best <= m[32:0];
    end
  end

  // Finish 4: arc angle times radius.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= {31'b0, best} * {33'b0, pr[2]};
    end
  end

  // Finish 5: round the arc, add both tangent legs, saturate; zero on an inside error.
  always_ff @(posedge clk) begin
    logic [64:0] rnd;
    logic [LEN_W:0] total;
    if (adv) begin
      rnd = {1'b0, prod} + (65'd1 << 29);
      total = (LEN_W+1)'(rnd[64:30]) + (LEN_W+1)'(pt[3][0]) + (LEN_W+1)'(pt[3][1]);
      if (total > LEN_MAX) begin
        total = LEN_MAX;
      end
      o_err <= pe[3];
      o_len <= pe[3] ? '0 : total[LEN_W-1:0];
    end
  end

  assign result.valid = o_valid;
  assign result.path_length = o_len;
  assign result.inside_error = o_err;

`ifndef SYNTHESIS
  // An inside point never reports a length.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_err |-> o_len == '0)
    else $error("inside error with nonzero path length");

  // The square root remainder stays within 2 * root.
  for (genvar p = 0; p < 2; p++) begin : g_chk
    a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
      sq_valid[SQ_STEPS] && !sq_err[SQ_STEPS] |->
        sq_lane[SQ_STEPS][p].rem <= (REM_W'(sq_lane[SQ_STEPS][p].root) << 1))
      else $error("square root remainder out of range");
  end

  // The first and last tangent angles of an outside point lie within one turn.
  a_ang_range: assert property (@(posedge clk) disable iff (rst)
    pv[0] && !pe[0] |-> ang[0] >= 0 && ang[0] < ANG_2PI && ang[3] >= 0 && ang[3] < ANG_2PI)
    else $error("tangent angle outside one turn");
`endif

endmodule

/* sim/tb.sv */
// Self-checking testbench for shortest_path_around_disk.
// Depends on spad_pkg, spad_query_if, spad_result_if and the RTL top level.
// A built-in predictor computes each path length; results are checked in order.
module tb;
  import spad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 1250;
  localparam int LATENCY = CORDIC_STEPS_DEF + 43;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] ANGLE_PI = 64'd3373259426;
  localparam logic [63:0] ANGLE_2PI = 64'd6746518852;

  typedef struct {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0] rad;
  } query_t;

  typedef struct {
    logic [39:0] len;
    logic err;
  } path_t;

  // One directed row; a typed-in expectation is used when known is set.
  typedef struct {
    query_t q;
    bit known;
    path_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  spad_query_if query ();
  spad_result_if result ();

  shortest_path_around_disk u_dut (
    .clk(clk),
    .rst(rst),
    .query(query.sink),
    .result(result.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  path_t expected_paths[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int inside_count = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  // Floor shift of a signed 64-bit value.
  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint elem_angle(int i);
    longint tbl[11] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                        16775850, 8388437, 4194282, 2097149, 1048575};
    if (i < 11) return tbl[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  // Vectoring CORDIC giving atan2(y, x) in Q30 radians.
  function automatic longint polar_angle(longint x, longint y);
    longint z, nx;
    z = 0;
    x = x * 268435456;
    y = y * 268435456;
    if (x < 0) begin
      z = (y >= 0) ? longint'(ANGLE_PI) : -longint'(ANGLE_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (y > 0) begin
        nx = x + fshift(y, i);
        y = y - fshift(x, i);
        z += elem_angle(i);
      end else begin
        nx = x - fshift(y, i);
        y = y + fshift(x, i);
        z -= elem_angle(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [33:0] floor_root(logic [69:0] n);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if (70'(c) * 70'(c) <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint one_turn(longint a);
    if (a < 0) a += longint'(ANGLE_2PI);
    if (a >= longint'(ANGLE_2PI)) a -= longint'(ANGLE_2PI);
    return a;
  endfunction

  // Shortest path around the disk from both tangent legs and the shorter arc.
  function automatic path_t predict_path(query_t q);
    path_t p;
    longint dx[2], dy[2], phi[2], beta[2], ta[2][2], gap, best;
    logic [69:0] d2, r2;
    logic [33:0] t[2];
    logic [63:0] arc;
    logic [69:0] total;
    bit in_disk;
    in_disk = 1'b0;
    dx[0] = longint'(q.ax) - longint'(q.cx);
    dy[0] = longint'(q.ay) - longint'(q.cy);
    dx[1] = longint'(q.bx) - longint'(q.cx);
    dy[1] = longint'(q.by) - longint'(q.cy);
    r2 = 70'(q.rad) * 70'(q.rad);
    for (int k = 0; k < 2; k++) begin
      d2 = 70'(dx[k] * dx[k]) + 70'(dy[k] * dy[k]);
      if (dx[k] * dx[k] < 0 || dy[k] * dy[k] < 0) begin
        d2 = 70'($unsigned(dx[k] * dx[k])) + 70'($unsigned(dy[k] * dy[k]));
      end
      if (d2 <= r2) begin
        in_disk = 1'b1;
      end else begin
        t[k] = floor_root(d2 - r2);
        phi[k] = polar_angle(dx[k], dy[k]);
        beta[k] = polar_angle(longint'(q.rad), longint'(t[k]));
        ta[k][0] = one_turn(phi[k] + beta[k]);
        ta[k][1] = one_turn(phi[k] - beta[k]);
      end
    end
    if (in_disk) begin
      p.len = '0;
      p.err = 1'b1;
      return p;
    end
    best = longint'(ANGLE_2PI);
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        gap = ta[0][i] - ta[1][j];
        if (gap < 0) gap = -gap;
        if (longint'(ANGLE_2PI) - gap < gap) gap = longint'(ANGLE_2PI) - gap;
        if (gap < best) best = gap;
      end
    end
    arc = (64'(best) * 64'(q.rad) + (64'd1 << 29)) >> 30;
    total = 70'(arc) + 70'(t[0]) + 70'(t[1]);
    p.len = (total > 70'h0FFFFFFFFFF) ? 40'hFFFFFFFFFF : total[39:0];
    p.err = 1'b0;
    return p;
  endfunction

  function automatic query_t make_query(int ax, int ay, int bx, int by, int cx, int cy,
                                        int rad);
    query_t q;
    q.ax = ax;
    q.ay = ay;
    q.bx = bx;
    q.by = by;
    q.cx = cx;
    q.cy = cy;
    q.rad = 31'(rad);
    return q;
  endfunction

  function automatic logic signed [31:0] rand_coord(int spread);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * spread)) - spread;
      2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  // Random query: points, center and radius mix full-range, spread-limited, extreme and small values.
  function automatic query_t random_query();
    query_t q;
    int spread;
    spread = 1 << $urandom_range(4, 30);
    q.cx = rand_coord(spread);
    q.cy = rand_coord(spread);
    q.ax = rand_coord(spread);
    q.ay = rand_coord(spread);
    q.bx = rand_coord(spread);
    q.by = rand_coord(spread);
    case ($urandom_range(0, 4))
      0: q.rad = 31'($urandom);
      1: q.rad = '0;
      2: q.rad = 31'h7FFFFFFF;
      default: q.rad = 31'($urandom_range(0, spread));
    endcase
    return q;
  endfunction

  // Drives one beat and holds it until the block takes it.
  task automatic send_query(query_t q);
    while (!calm && $urandom_range(0, 99) < 16) begin
      query.valid <= 1'b0;
      @(posedge clk);
    end
    query.valid <= 1'b1;
    query.first_x <= q.ax;
    query.first_y <= q.ay;
    query.second_x <= q.bx;
    query.second_y <= q.by;
    query.center_x <= q.cx;
    query.center_y <= q.cy;
    query.radius <= q.rad;
    expected_paths.insert(expected_paths.size(), predict_path(q));
    @(posedge clk);
    while (!query.ready) @(posedge clk);
    accepted++;
  endtask

  // Result side: random stall, then compare each beat with the oldest expectation.
  always @(posedge clk) begin
    path_t want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_paths.size() == 0) begin
          $display("%0t: unexpected result len=%0d err=%0b", $time,
                   result.path_length, result.inside_error);
          errors++;
        end else begin
          want = expected_paths.pop_front();
          checked++;
          if (want.err) inside_count++;
          if (result.path_length !== want.len) begin
            $display("%0t: path_length expected %0d actual %0d", $time, want.len,
                     result.path_length);
            errors++;
          end
          if (result.inside_error !== want.err) begin
            $display("%0t: inside_error expected %0b actual %0b", $time, want.err,
                     result.inside_error);
            errors++;
          end
        end
      end
      result.ready <= calm || ($urandom_range(0, 99) >= 16);
    end
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((query.valid && query.ready) || (result.valid && result.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** shortest_path_around_disk: FAILED **");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    path_t got;
    query.valid = 1'b0;
    query.first_x = '0;
    query.first_y = '0;
    query.second_x = '0;
    query.second_y = '0;
    query.center_x = '0;
    query.center_y = '0;
    query.radius = '0;
    result.ready = 1'b0;
    // Point on the center of a zero radius: inside error.
    rw.known = 1; rw.want.len = 0; rw.want.err = 1;
    rw.q = make_query(0, 0, 5, 5, 0, 0, 0); rows.insert(rows.size(), rw);
    // Point exactly on the circle: inside error.
    rw.q = make_query(65536, 0, 0, 200000, 0, 0, 65536); rows.insert(rows.size(), rw);
    // Second point inside.
    rw.q = make_query(1000000, 0, 10, 10, 0, 0, 65536); rows.insert(rows.size(), rw);
    // Largest radius, first point on the circle and second just outside: inside error.
    rw.q = make_query(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 32'h7FFFFFFF);
    rows.insert(rows.size(), rw);
    // Zero radius: sum of the two distances.
    rw.want.err = 0;
    rw.q = make_query(3, 4, -6, -8, 0, 0, 0); rw.want.len = 15; rows.insert(rows.size(), rw);
    rw.q = make_query(0, 0, 0, 0, 7, 0, 0); rw.want.len = 14; rows.insert(rows.size(), rw);
    rw.known = 0;
    rw.q = make_query(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h7FFFFFFF, 0);
    rows.insert(rows.size(), rw);
    rw.q = make_query(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    rows.insert(rows.size(), rw);
    rw.q = make_query(200000, 0, -200000, 0, 0, 0, 65536); rows.insert(rows.size(), rw);
    rw.q = make_query(0, 200000, 0, -200000, 0, 0, 65536); rows.insert(rows.size(), rw);
    rw.q = make_query(200000, 1, 200000, -1, 0, 0, 65536); rows.insert(rows.size(), rw);
    rw.q = make_query(-200000, 0, -200000, 0, 0, 0, 199999); rows.insert(rows.size(), rw);
    rw.q = make_query(-5, 0, 0, -5, 0, 0, 4); rows.insert(rows.size(), rw);
    rw.q = make_query(32'h80000000, 0, 32'h7FFFFFFF, 0, 0, 0, 32'h7FFFFFFF);
    rows.insert(rows.size(), rw);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].known) begin
        got = predict_path(rows[k].q);
        if (got.len !== rows[k].want.len || got.err !== rows[k].want.err) begin
          $display("%0t: directed row %0d expected len=%0d err=%0b actual len=%0d err=%0b",
                   $time, k, rows[k].want.len, rows[k].want.err, got.len, got.err);
          errors++;
        end
      end
      send_query(rows[k].q);
      if (rows[k].known) expected_paths[$] = rows[k].want;
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 400 && n < 600);
      send_query(random_query());
    end
    calm = 1'b0;
    query.valid <= 1'b0;

    while (expected_paths.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d queries, checked %0d results, %0d of them inside-disk errors.",
             accepted, checked, inside_count);
    if (errors == 0) begin
      $display("** shortest_path_around_disk: PASSED **");
    end else begin
      $display("** shortest_path_around_disk: FAILED **");
    end
    $finish;
  end
endmodule
